FILE: hw/rtl/osdtlo_pkg.sv
// ----------------------------------------------------------------------------
// OSD text luma overlay package
// Shared constants, register indexes and the 5x7 digit font for the overlay.
// ----------------------------------------------------------------------------
`default_nettype none

package osdtlo_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_TEXT_CHARS = 32;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W       = 5;
  localparam int LUMA_W      = 8;
  localparam int CODE_W      = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CHARS_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CHARS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LENGTH     = 2'd2;

  localparam logic [LEN_W-1:0]  TEXT_LENGTH_RST = 5'd19;
  localparam logic [LUMA_W-1:0] LUMA_TEXT = 8'd235;
  localparam logic [LUMA_W-1:0] LUMA_BOX  = 8'd16;

  localparam int TEXT_X0   = 10;
  localparam int TEXT_Y0   = 10;
  localparam int BOX_X0    = 8;
  localparam int BOX_Y0    = 8;
  localparam int BOX_H     = 18;
  localparam int BOX_PAD   = 3;
  localparam int CELL_W    = 11;
  localparam int GLYPH_W   = 5;
  localparam int GLYPH_H   = 7;
  localparam int GLYPH_SCALE = 2;

  // Widest text span is 32 cells; dx below this bound covers every cell.
  localparam int TEXT_SPAN  = 32 * CELL_W;
  localparam int DX_W       = 9;
  // idx = (dx * DIV11_MUL) >> DIV11_SHIFT is exact for dx below TEXT_SPAN.
  localparam int DIV11_MUL   = 373;
  localparam int DIV11_SHIFT = 12;
  localparam int DIV11_PROD_W = 18;

  function automatic logic [GLYPH_W-1:0] glyph_row(input logic [CODE_W-1:0] code,
                                                   input logic [2:0] gy);
    logic [GLYPH_H-1:0][GLYPH_W-1:0] rows;
    logic [GLYPH_W-1:0] bits;
    case (code)
      4'd0:  rows = {5'h0E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h0E};
      4'd1:  rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0C, 5'h04};
      4'd2:  rows = {5'h1F, 5'h08, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      4'd3:  rows = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      4'd4:  rows = {5'h02, 5'h02, 5'h1F, 5'h12, 5'h0A, 5'h06, 5'h02};
      4'd5:  rows = {5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F};
      4'd6:  rows = {5'h0E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h0E};
      4'd7:  rows = {5'h08, 5'h08, 5'h08, 5'h04, 5'h02, 5'h01, 5'h1F};
      4'd8:  rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      4'd9:  rows = {5'h0E, 5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0E};
      4'd10: rows = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      4'd11: rows = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      default: rows = '0;
    endcase
    case (gy)
      3'd0: bits = rows[0];
      3'd1: bits = rows[1];
      3'd2: bits = rows[2];
      3'd3: bits = rows[3];
      3'd4: bits = rows[4];
      3'd5: bits = rows[5];
      3'd6: bits = rows[6];
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/osd_text_luma_overlay_core.sv
// ----------------------------------------------------------------------------
// OSD text luma overlay core
// Draws a dark box and a line of scaled 5x7 digits over a luma pixel stream.
// ----------------------------------------------------------------------------
//  Channel  Ports                                  Transfer when
//  input    start, busy, in_pixel_luma/column/row   start high, busy low
//  result   out_valid, out_luma_out, out_overlay_hit out_valid high
//  config   cfg_we, cfg_index, cfg_data             cfg_we high
//
//  One pixel is taken every cycle; busy stays low.
//  The result passes the input register, then the font lookup and compare
//  logic into the result register.
//  Reset clears the text registers and sets the text length to 19.
//  The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_text_luma_overlay_core #(
  parameter int COORD_BITS = osdtlo_pkg::COORD_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [osdtlo_pkg::LUMA_W-1:0]         in_pixel_luma,
  input  wire  [COORD_BITS-1:0]                 in_pixel_column,
  input  wire  [COORD_BITS-1:0]                 in_pixel_row,
  output logic                                  out_valid,
  output logic [osdtlo_pkg::LUMA_W-1:0]         out_luma_out,
  output logic                                  out_overlay_hit,
  input  wire                                   cfg_we,
  input  wire  [osdtlo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [osdtlo_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import osdtlo_pkg::*;

  localparam int XW = COORD_BITS + 1;
  localparam int IDX_W = LEN_W;

  logic [CFG_DATA_W-1:0] chars_low_r;
  logic [CFG_DATA_W-1:0] chars_high_r;
  logic [LEN_W-1:0]      text_len_r;

  logic                  in_valid_r;
  logic [LUMA_W-1:0]     in_luma_r;
  logic [COORD_BITS-1:0] in_col_r;
  logic [COORD_BITS-1:0] in_row_r;

  logic                  out_valid_nxt;
  logic [LUMA_W-1:0]     luma_nxt;
  logic                  hit_nxt;

  logic [XW-1:0]           col_x;
  logic [XW-1:0]           row_x;
  logic [XW-1:0]           dx;
  logic [XW-1:0]           dy;
  logic [XW-1:0]           box_w;
  logic                    in_box;
  logic                    text_band;
  logic [DX_W-1:0]         dx_s;
  logic [DIV11_PROD_W-1:0] div_prod;
  logic [IDX_W-1:0]        cell_idx;
  logic [DX_W-1:0]         cell_base;
  logic [CODE_W-1:0]       cell_off;
  logic [2:0]              gx;
  logic [2:0]              gy;
  logic [2*CFG_DATA_W-1:0] chars_all;
  logic [CODE_W-1:0]       code;
  logic [GLYPH_W-1:0]      row_bits;
  logic                    lit;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r  <= '0;
      chars_high_r <= '0;
      text_len_r   <= TEXT_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_CHARS_LOW:  chars_low_r  <= cfg_data;
        CFG_IDX_CHARS_HIGH: chars_high_r <= cfg_data;
        CFG_IDX_LENGTH:     text_len_r   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      in_valid_r <= start;
      out_valid  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_luma_r       <= in_pixel_luma;
    in_col_r        <= in_pixel_column;
    in_row_r        <= in_pixel_row;
    out_luma_out    <= luma_nxt;
    out_overlay_hit <= hit_nxt;
  end

  always_comb begin
    col_x = {1'b0, in_col_r};
    row_x = {1'b0, in_row_r};
    dx    = col_x - XW'(TEXT_X0);
    dy    = row_x - XW'(TEXT_Y0);

    box_w  = XW'(text_len_r) * XW'(CELL_W) + XW'(BOX_PAD);
    in_box = (col_x >= XW'(BOX_X0)) && (col_x < XW'(BOX_X0) + box_w) &&
             (row_x >= XW'(BOX_Y0)) && (row_x < XW'(BOX_Y0 + BOX_H));

    text_band = (col_x >= XW'(TEXT_X0)) && (row_x >= XW'(TEXT_Y0)) &&
                (dy < XW'(GLYPH_H * GLYPH_SCALE)) && (dx < XW'(TEXT_SPAN));

    dx_s      = dx[DX_W-1:0];
    div_prod  = DIV11_PROD_W'(dx_s) * DIV11_PROD_W'(DIV11_MUL);
    cell_idx  = div_prod[DIV11_SHIFT +: IDX_W];
    cell_base = DX_W'(cell_idx) * DX_W'(CELL_W);
    cell_off  = CODE_W'(dx_s - cell_base);
    gx        = cell_off[3:1];
    gy        = dy[3:1];

    chars_all = {chars_high_r, chars_low_r};
    if ((IDX_W + 1)'(cell_idx) >= (IDX_W + 1)'(MAX_TEXT_CHARS)) begin
      code = 4'd12;
    end else begin
      code = chars_all[{cell_idx, 2'b00} +: CODE_W];
    end
    row_bits = glyph_row(code, gy);

    lit = text_band && (cell_idx < text_len_r) &&
          (cell_off < CODE_W'(GLYPH_W * GLYPH_SCALE)) &&
          row_bits[3'(GLYPH_W - 1) - gx];

    out_valid_nxt = in_valid_r;
    if (lit) begin
      luma_nxt = LUMA_TEXT;
      hit_nxt  = 1'b1;
    end else if (in_box) begin
      luma_nxt = LUMA_BOX;
      hit_nxt  = 1'b1;
    end else begin
      luma_nxt = in_luma_r;
      hit_nxt  = 1'b0;
    end
  end

endmodule

`default_nettype wire
